// ===== rtl/core/oile_pkg.sv =====
// ----------------------------------------------------------------------------
// oile_pkg - ordered item list engine shared definitions
// Beat types, action and status codes, link write command.
// ----------------------------------------------------------------------------
`default_nettype none

package oile_pkg;

   localparam int MAX_ITEMS = 16;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int NODE_W    = $clog2(MAX_ITEMS + 1);

   localparam int ACT_W    = 2;
   localparam int HANDLE_W = 4;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 5;
   localparam int STAT_W   = 2;

   localparam logic [NODE_W-1:0] SENT    = NODE_W'(MAX_ITEMS);
   localparam logic [KEY_W-1:0]  KEY_TOP = '1;

   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_MEMBER = 2'd2;

   typedef logic [NODE_W-1:0] node_type;

   typedef struct packed {
      logic [ACT_W-1:0]    action;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  item_count;
      logic [STAT_W-1:0]   status;
      logic                head_valid;
      logic [HANDLE_W-1:0] head_handle;
      logic [KEY_W-1:0]    head_key;
   } rsp_type;

   // node SENT addresses the head/tail registers instead of the link memory
   typedef struct packed {
      logic     next_we;
      node_type next_node;
      node_type next_val;
      logic     prev_we;
      node_type prev_node;
      node_type prev_val;
   } link_wr_type;

endpackage

`default_nettype wire

// ===== rtl/core/oile_links.sv =====
// ----------------------------------------------------------------------------
// oile_links - link store of the ordered item list
// Next/prev link memories for the items plus the sentinel's head and tail
// registers; one write per memory and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oile_links import oile_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [IDX_W-1:0]  rd_idx,
   input  wire link_wr_type       wr,
   output node_type               rd_next,
   output node_type               rd_prev,
   output node_type               head,
   output node_type               tail
);

   node_type next_mem [MAX_ITEMS];
   node_type prev_mem [MAX_ITEMS];
   node_type rd_next_ff;
   node_type rd_prev_ff;
   node_type head_ff;
   node_type tail_ff;

   always_ff @(posedge clock) begin
      if (wr.next_we && (wr.next_node != SENT)) begin
         next_mem[wr.next_node[IDX_W-1:0]] <= wr.next_val;
      end
      if (wr.prev_we && (wr.prev_node != SENT)) begin
         prev_mem[wr.prev_node[IDX_W-1:0]] <= wr.prev_val;
      end
      rd_next_ff <= next_mem[rd_idx];
      rd_prev_ff <= prev_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= SENT;
         tail_ff <= SENT;
      end else begin
         if (wr.next_we && (wr.next_node == SENT)) begin
            head_ff <= wr.next_val;
         end
         if (wr.prev_we && (wr.prev_node == SENT)) begin
            tail_ff <= wr.prev_val;
         end
      end
   end

   assign rd_next = rd_next_ff;
   assign rd_prev = rd_prev_ff;
   assign head    = head_ff;
   assign tail    = tail_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_item_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_item_list_engine - sorted doubly linked list of item handles
// Append, sorted insert and remove on a ring closed by a sentinel node.
// A sorted insert walks the key and link memories with one key compare per
// cycle. One beat in flight at a time; the next beat is taken once the
// result is out. Reset empties the list at once.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_item_list_engine import oile_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK_CMP,
      S_LINK1,
      S_LINK2,
      S_RM_WR,
      S_HK_RD,
      S_HK_OUT
   } state_type;

   state_type             state_ff;
   logic [HANDLE_W-1:0]   hdl_ff;
   logic [KEY_W-1:0]      key_ff;
   node_type              at_ff;
   node_type              cur_ff;
   logic [STAT_W-1:0]     status_ff;
   node_type              count_ff;
   logic [MAX_ITEMS-1:0]  member_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [KEY_W-1:0]      key_mem [MAX_ITEMS];
   logic [KEY_W-1:0]      key_rd_ff;

   logic                  accept;
   logic                  in_range;
   logic                  req_member;
   logic                  key_we;
   logic                  key_le;
   logic                  rsp_free;
   logic                  head_ok;
   logic [IDX_W-1:0]      req_idx;
   logic [IDX_W-1:0]      hdl_idx;
   logic [IDX_W-1:0]      rd_idx;
   node_type              hdl_node;
   node_type              head;
   node_type              tail;
   node_type              rd_next;
   node_type              rd_prev;
   link_wr_type           link_wr;

   oile_links u_links (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .wr      (link_wr),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .head    (head),
      .tail    (tail)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign req_idx    = IDX_W'(req_data.handle);
   assign in_range   = (NODE_W'(req_data.handle) < SENT);
   assign req_member = member_ff[req_idx];
   assign hdl_idx    = IDX_W'(hdl_ff);
   assign hdl_node   = NODE_W'(hdl_ff);
   assign key_le     = (key_rd_ff <= key_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign head_ok    = (count_ff != '0) && (head != SENT);
   assign key_we     = accept && in_range && !req_member
                       && ((req_data.action == ACT_APPEND) || (req_data.action == ACT_INSERT));

   always_comb begin
      unique case (state_ff)
         S_IDLE:     rd_idx = (req_data.action == ACT_REMOVE) ? req_idx : head[IDX_W-1:0];
         S_WALK_CMP: rd_idx = rd_next[IDX_W-1:0];
         default:    rd_idx = head[IDX_W-1:0];
      endcase
   end

   always_comb begin
      link_wr = '0;
      unique case (state_ff)
         S_LINK1: begin
            link_wr.next_we   = 1'b1;
            link_wr.next_node = hdl_node;
            link_wr.next_val  = cur_ff;
            link_wr.prev_we   = 1'b1;
            link_wr.prev_node = hdl_node;
            link_wr.prev_val  = at_ff;
         end
         S_LINK2: begin
            link_wr.next_we   = 1'b1;
            link_wr.next_node = at_ff;
            link_wr.next_val  = hdl_node;
            link_wr.prev_we   = 1'b1;
            link_wr.prev_node = cur_ff;
            link_wr.prev_val  = hdl_node;
         end
         S_RM_WR: begin
            link_wr.next_we   = 1'b1;
            link_wr.next_node = rd_prev;
            link_wr.next_val  = rd_next;
            link_wr.prev_we   = 1'b1;
            link_wr.prev_node = rd_next;
            link_wr.prev_val  = rd_prev;
         end
         default: begin
            link_wr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_idx] <= req_data.key;
      end
      key_rd_ff <= key_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         member_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_free) begin
            rsp_valid_ff <= (state_ff == S_HK_OUT);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  hdl_ff <= req_data.handle;
                  key_ff <= req_data.key;
                  priority if (req_data.action == ACT_NONE) begin
                     status_ff <= STAT_OK;
                     state_ff  <= S_HK_RD;
                  end else if (!in_range) begin
                     status_ff <= STAT_NOT_MEMBER;
                     state_ff  <= S_HK_RD;
                  end else if (req_data.action == ACT_REMOVE) begin
                     if (req_member) begin
                        status_ff <= STAT_OK;
                        state_ff  <= S_RM_WR;
                     end else begin
                        status_ff <= STAT_NOT_MEMBER;
                        state_ff  <= S_HK_RD;
                     end
                  end else if (req_member) begin
                     status_ff <= STAT_DUPLICATE;
                     state_ff  <= S_HK_RD;
                  end else if ((req_data.action == ACT_APPEND) || (req_data.key == KEY_TOP)) begin
                     status_ff <= STAT_OK;
                     at_ff     <= tail;
                     cur_ff    <= SENT;
                     state_ff  <= S_LINK1;
                  end else if (head == SENT) begin
                     status_ff <= STAT_OK;
                     at_ff     <= SENT;
                     cur_ff    <= SENT;
                     state_ff  <= S_LINK1;
                  end else begin
                     status_ff <= STAT_OK;
                     at_ff     <= SENT;
                     cur_ff    <= head;
                     state_ff  <= S_WALK_CMP;
                  end
               end
            end
            S_WALK_CMP: begin
               if (key_le) begin
                  at_ff  <= cur_ff;
                  cur_ff <= rd_next;
                  if (rd_next == SENT) begin
                     state_ff <= S_LINK1;
                  end
               end else begin
                  state_ff <= S_LINK1;
               end
            end
            S_LINK1: begin
               state_ff <= S_LINK2;
            end
            S_LINK2: begin
               member_ff[hdl_idx] <= 1'b1;
               count_ff           <= count_ff + 1'b1;
               state_ff           <= S_HK_RD;
            end
            S_RM_WR: begin
               member_ff[hdl_idx] <= 1'b0;
               count_ff           <= count_ff - 1'b1;
               state_ff           <= S_HK_RD;
            end
            S_HK_RD: begin
               state_ff <= S_HK_OUT;
            end
            S_HK_OUT: begin
               if (rsp_free) begin
                  rsp_ff.item_count  <= COUNT_W'(count_ff);
                  rsp_ff.status      <= status_ff;
                  rsp_ff.head_valid  <= head_ok;
                  rsp_ff.head_handle <= head_ok ? HANDLE_W'(head) : '0;
                  rsp_ff.head_key    <= head_ok ? key_rd_ff : '0;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SENT)
      else $error("item count above capacity");

   a_member_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(member_ff) == int'(count_ff)))
      else $error("membership bits disagree with item count");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((head == SENT) == (count_ff == '0)))
      else $error("head link disagrees with item count");

   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((tail == SENT) == (head == SENT)))
      else $error("head and tail links disagree on empty list");

endmodule

`default_nettype wire
